// ===== design/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  // Fixed field widths of the request and result ports
  localparam int TagW  = 16;
  localparam int PrioW = 3;
  localparam int LimW  = 7;

  // Pointer table commands
  typedef enum logic [1:0] {
    PT_NOP,
    PT_APPEND,
    PT_POP,
    PT_HALVE
  } spq_pt_op_e;

  typedef struct packed {
    spq_pt_op_e             op;
    logic [PrioW-1:0]       cls;
  } spq_pt_cmd_t;

endpackage

`default_nettype wire

// ===== design/spq_tag_mem.sv =====
`default_nettype none

module spq_tag_mem #(
  parameter int Depth = 128,
  parameter int AddrW = 7,
  parameter int DataW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/spq_ptr_table.sv =====
`default_nettype none

module spq_ptr_table
  import spq_pkg::*;
#(
  parameter int NCls   = 8,
  parameter int ClsW   = 3,
  parameter int QDepth = 16,
  parameter int PosW   = 4,
  parameter int CntW   = 5,
  parameter int Keep   = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire spq_pt_cmd_t       cmd_i,
  input  wire logic [PrioW-1:0]  rd_cls_i,
  output logic      [PosW-1:0]   rd_head_o,
  output logic      [CntW-1:0]   rd_cnt_o,
  output logic                   any_o,
  output logic      [ClsW-1:0]   top_cls_o,
  output logic      [PosW-1:0]   top_head_o,
  output logic                   top_last_o
);

  logic [PosW-1:0] head_q [NCls];
  logic [PosW-1:0] head_d [NCls];
  logic [CntW-1:0] cnt_q  [NCls];
  logic [CntW-1:0] cnt_d  [NCls];
  logic [NCls-1:0] busy;
  logic [NCls-1:0] busy_after;
  logic [ClsW-1:0] cmd_idx;

  assign cmd_idx = cmd_i.cls[ClsW-1:0];

  always_comb begin
    for (int c = 0; c < NCls; c++) begin
      busy[c] = (cnt_q[c] != '0);
    end
  end

  // Highest nonempty class wins
  always_comb begin
    top_cls_o = '0;
    for (int c = 0; c < NCls; c++) begin
      if (busy[c]) begin
        top_cls_o = ClsW'(c);
      end
    end
  end

  always_comb begin
    busy_after = busy;
    if (cnt_q[top_cls_o] == CntW'(1)) begin
      busy_after[top_cls_o] = 1'b0;
    end
  end

  assign any_o      = (busy != '0);
  assign top_head_o = head_q[top_cls_o];
  assign top_last_o = (busy_after == '0);
  assign rd_head_o  = head_q[rd_cls_i[ClsW-1:0]];
  assign rd_cnt_o   = cnt_q[rd_cls_i[ClsW-1:0]];

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    case (cmd_i.op)
      PT_APPEND: begin
        cnt_d[cmd_idx] = cnt_q[cmd_idx] + CntW'(1);
      end
      PT_POP: begin
        cnt_d[cmd_idx] = cnt_q[cmd_idx] - CntW'(1);
        if (head_q[cmd_idx] == PosW'(QDepth - 1)) begin
          head_d[cmd_idx] = '0;
        end else begin
          head_d[cmd_idx] = head_q[cmd_idx] + PosW'(1);
        end
      end
      PT_HALVE: begin
        cnt_d[cmd_idx] = CntW'(Keep);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCls; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/strict_priority_packet_queues.sv =====
`default_nettype none

// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+-----------------------------------------
// in      | input     | in_valid_i/in_stall_o | kind, packet_tag, priority_req, burst_limit
// out     | output    | out_valid_o/out_stall_i | sent_tag, sent_priority, none_sent, last
//
// A receive request is taken while idle; when it overfills its class it is followed by a
// compaction pass over the tag memory.
// A send request handles each result as a memory read, then an output load; the tag memory
// has a single read port. An output stall holds the send in its wait state.
// Reset clears the head and count of every class; the tag memory needs no clearing.
// The input takes a new request whenever the control is idle, even while a result waits.

module strict_priority_packet_queues
  import spq_pkg::*;
#(
  parameter int NUM_PRIORITIES = 8,
  parameter int QUEUE_LIMIT    = 15,
  parameter int TAG_BITS       = 16,
  parameter int MAX_BURST      = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             kind_i,
  input  wire logic [TagW-1:0]  packet_tag_i,
  input  wire logic [PrioW-1:0] priority_req_i,
  input  wire logic [LimW-1:0]  burst_limit_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [TagW-1:0]  sent_tag_o,
  output logic      [PrioW-1:0] sent_priority_o,
  output logic                  none_sent_o,
  output logic                  last_o
);

  // Only classes reachable through the 3-bit priority field hold tags
  localparam int NCls     = (NUM_PRIORITIES < (1 << PrioW)) ? NUM_PRIORITIES : (1 << PrioW);
  localparam int ClsW     = (NCls > 1) ? $clog2(NCls) : 1;
  localparam int QDepth   = QUEUE_LIMIT + 1;
  localparam int PosW     = $clog2(QDepth);
  localparam int CntW     = $clog2(QDepth + 1);
  localparam int Keep     = (QDepth + 1) / 2;
  localparam int LeftW    = $clog2(Keep + 1);
  localparam int StoreW   = (TAG_BITS < TagW) ? TAG_BITS : TagW;
  localparam int AddrW    = ClsW + PosW;
  localparam int MemDepth = NCls * (1 << PosW);

  localparam logic KIND_RX = 1'b0;

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_CMP       = 2'd1;
  localparam logic [1:0] ST_SEND_RD   = 2'd2;
  localparam logic [1:0] ST_SEND_WAIT = 2'd3;

  // Fold a position sum below 2 * QDepth back into the ring
  function automatic logic [PosW-1:0] wrap_pos(input logic [PosW:0] s);
    logic [PosW:0] r;
    r = s;
    if (s >= (PosW + 1)'(QDepth)) begin
      r = s - (PosW + 1)'(QDepth);
    end
    return r[PosW-1:0];
  endfunction

  logic [1:0]       state_q, state_d;

  // Compaction context
  logic [ClsW-1:0]  cmp_cls_q, cmp_cls_d;
  logic [PosW-1:0]  cmp_rd_q, cmp_rd_d;
  logic [PosW-1:0]  cmp_wr_q, cmp_wr_d;
  logic [LeftW-1:0] cmp_left_q, cmp_left_d;
  logic             cmp_pend_q, cmp_pend_d;

  // Send context
  logic [LimW-1:0]  lim_q, lim_d;
  logic [LimW-1:0]  sent_q, sent_d;
  logic [ClsW-1:0]  pri_q, pri_d;
  logic             none_q, none_d;
  logic             fin_q, fin_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [TagW-1:0]  tag_q, tag_d;
  logic [PrioW-1:0] opri_q, opri_d;
  logic             onone_q, onone_d;
  logic             olast_q, olast_d;

  // Memory and pointer table ports
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [StoreW-1:0] mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [StoreW-1:0] mem_rdata;

  spq_pt_cmd_t       pt_cmd;
  logic [PosW-1:0]   rd_head;
  logic [CntW-1:0]   rd_cnt;
  logic              any;
  logic [ClsW-1:0]   top_cls;
  logic [PosW-1:0]   top_head;
  logic              top_last;

  logic              in_acc;
  logic              cls_ok;
  logic              out_free;
  logic [LimW-1:0]   lim_sat;

  spq_tag_mem #(
    .Depth (MemDepth),
    .AddrW (AddrW),
    .DataW (StoreW)
  ) u_tag_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  spq_ptr_table #(
    .NCls   (NCls),
    .ClsW   (ClsW),
    .QDepth (QDepth),
    .PosW   (PosW),
    .CntW   (CntW),
    .Keep   (Keep)
  ) u_ptr_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pt_cmd),
    .rd_cls_i   (priority_req_i),
    .rd_head_o  (rd_head),
    .rd_cnt_o   (rd_cnt),
    .any_o      (any),
    .top_cls_o  (top_cls),
    .top_head_o (top_head),
    .top_last_o (top_last)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cls_ok     = (int'(priority_req_i) < NCls);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Clamp the burst limit to 1..MAX_BURST
  always_comb begin
    lim_sat = burst_limit_i;
    if (burst_limit_i == '0) begin
      lim_sat = LimW'(1);
    end else if (burst_limit_i > LimW'(MAX_BURST)) begin
      lim_sat = LimW'(MAX_BURST);
    end
  end

  always_comb begin
    state_d     = state_q;
    cmp_cls_d   = cmp_cls_q;
    cmp_rd_d    = cmp_rd_q;
    cmp_wr_d    = cmp_wr_q;
    cmp_left_d  = cmp_left_q;
    cmp_pend_d  = cmp_pend_q;
    lim_d       = lim_q;
    sent_d      = sent_q;
    pri_d       = pri_q;
    none_d      = none_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && out_stall_i;
    tag_d       = tag_q;
    opri_d      = opri_q;
    onone_d     = onone_q;
    olast_d     = olast_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    pt_cmd      = '{op: PT_NOP, cls: '0};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_RX) begin
            if (cls_ok) begin
              // Append at head + count, then compact if the class overflowed
              mem_we    = 1'b1;
              mem_waddr = {priority_req_i[ClsW-1:0],
                           wrap_pos((PosW + 1)'(rd_head) + (PosW + 1)'(rd_cnt))};
              mem_wdata = packet_tag_i[StoreW-1:0];
              pt_cmd    = '{op: PT_APPEND, cls: priority_req_i};
              if (rd_cnt == CntW'(QUEUE_LIMIT)) begin
                cmp_cls_d  = priority_req_i[ClsW-1:0];
                cmp_rd_d   = wrap_pos((PosW + 1)'(rd_head) + (PosW + 1)'(2));
                cmp_wr_d   = wrap_pos((PosW + 1)'(rd_head) + (PosW + 1)'(1));
                cmp_left_d = LeftW'(Keep - 1);
                cmp_pend_d = 1'b0;
                state_d    = ST_CMP;
              end
            end
          end else begin
            lim_d   = lim_sat;
            sent_d  = '0;
            state_d = ST_SEND_RD;
          end
        end
      end

      ST_CMP: begin
        // Read position h + 2k, write it back to h + k in the following cycle
        if (cmp_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = {cmp_cls_q, cmp_wr_q};
          mem_wdata = mem_rdata;
          cmp_wr_d  = wrap_pos((PosW + 1)'(cmp_wr_q) + (PosW + 1)'(1));
        end
        if (cmp_left_q != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = {cmp_cls_q, cmp_rd_q};
          cmp_rd_d   = wrap_pos((PosW + 1)'(cmp_rd_q) + (PosW + 1)'(2));
          cmp_left_d = cmp_left_q - LeftW'(1);
        end
        cmp_pend_d = (cmp_left_q != '0);
        if ((cmp_left_q == '0) && !cmp_pend_q) begin
          pt_cmd  = '{op: PT_HALVE, cls: PrioW'(cmp_cls_q)};
          state_d = ST_IDLE;
        end
      end

      ST_SEND_RD: begin
        if (!any) begin
          none_d  = 1'b1;
          fin_d   = 1'b1;
          state_d = ST_SEND_WAIT;
        end else begin
          // Pop the head of the highest nonempty class
          mem_re    = 1'b1;
          mem_raddr = {top_cls, top_head};
          pt_cmd    = '{op: PT_POP, cls: PrioW'(top_cls)};
          pri_d     = top_cls;
          none_d    = 1'b0;
          fin_d     = ((sent_q + LimW'(1)) == lim_q) || top_last;
          sent_d    = sent_q + LimW'(1);
          state_d   = ST_SEND_WAIT;
        end
      end

      ST_SEND_WAIT: begin
        // Hold the read data until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          tag_d       = none_q ? '0 : TagW'(mem_rdata);
          opri_d      = none_q ? '0 : PrioW'(pri_q);
          onone_d     = none_q;
          olast_d     = fin_q;
          state_d     = fin_q ? ST_IDLE : ST_SEND_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_left_q  <= '0;
      cmp_pend_q  <= 1'b0;
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_left_q  <= cmp_left_d;
      cmp_pend_q  <= cmp_pend_d;
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_cls_q <= cmp_cls_d;
    cmp_rd_q  <= cmp_rd_d;
    cmp_wr_q  <= cmp_wr_d;
    lim_q     <= lim_d;
    pri_q     <= pri_d;
    none_q    <= none_d;
    fin_q     <= fin_d;
    tag_q     <= tag_d;
    opri_q    <= opri_d;
    onone_q   <= onone_d;
    olast_q   <= olast_d;
  end

  assign out_valid_o     = out_valid_q;
  assign sent_tag_o      = tag_q;
  assign sent_priority_o = opri_q;
  assign none_sent_o     = onone_q;
  assign last_o          = olast_q;

  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND_RD) |-> (sent_q < lim_q))
    else $error("send burst ran past its limit");

  a_load_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_SEND_WAIT))
    else $error("result loaded outside the send wait state");

  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND_WAIT && out_valid_o && out_stall_i) |=> (state_q == ST_SEND_WAIT))
    else $error("send advanced while the output was stalled");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_sent_o) |-> last_o)
    else $error("empty send result not marked last");

  a_cmp_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && cmp_pend_q) |=> (state_q == ST_CMP))
    else $error("compaction ended with a write pending");

endmodule

`default_nettype wire
